### rtl/jcam_pkg.sv
package jcam_pkg;

  // sizes of the sample and result fields
  localparam int ADC_BITS       = 12;
  localparam int FULL_SCALE_OUT = 1000;
  localparam int OUT_W          = 11;

  // arithmetic widths
  localparam int SW       = ADC_BITS + 1;             // signed sample difference
  localparam int EW       = ADC_BITS + 2;             // signed edge and span
  localparam int PROD_W   = 2 * SW;                   // multiplier product
  localparam int ACC_W    = PROD_W + 1;               // sum of two squares
  localparam int QUO_W    = $clog2(FULL_SCALE_OUT + 1);
  localparam int NUM_W    = ADC_BITS + QUO_W;         // scaled numerator
  localparam int DEN_W    = ADC_BITS + 1;             // divisor and remainder
  localparam int CNT_W    = $clog2(QUO_W);

  localparam logic [ADC_BITS-1:0] DEADZONE_RESET = ADC_BITS'(100);
  localparam logic [ADC_BITS-1:0] ADC_FULL       = {ADC_BITS{1'b1}};

  typedef logic [ADC_BITS-1:0]     sample_t;
  typedef logic signed [OUT_W-1:0] axis_t;
  typedef logic signed [OUT_W:0]   wide_t;

  // input operation codes
  typedef enum logic {
    OP_NORMAL = 1'b0,
    OP_REFINE = 1'b1
  } op_t;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ_X,
    S_SQ_Y,
    S_SQ_R,
    S_CMP,
    S_SETUP,
    S_DINIT,
    S_DIV,
    S_STORE,
    S_FINISH
  } state_t;

  // multiplier operand selection
  typedef enum logic [1:0] {
    MUL_DX,
    MUL_DY,
    MUL_DZ,
    MUL_NUM
  } mul_sel_t;

  // segment of the axis transfer curve
  typedef enum logic [2:0] {
    SEG_ZERO,
    SEG_LOW,
    SEG_HIGH,
    SEG_MIN_END,
    SEG_MAX_END
  } seg_t;

  // controller to datapath
  typedef struct packed {
    logic     load;
    mul_sel_t mul_sel;
    logic     acc_load;
    logic     acc_add;
    logic     cmp;
    logic     axis;
    logic     setup;
    logic     dinit;
    logic     div_step;
    logic     store;
    logic     finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_last;
  } status_t;

  // clamp to the output range
  function automatic axis_t sat_out(input wide_t v);
    wide_t hi;
    wide_t lo;
    hi = wide_t'(FULL_SCALE_OUT);
    lo = -wide_t'(FULL_SCALE_OUT);
    if (v > hi) begin
      return axis_t'(hi);
    end else if (v < lo) begin
      return axis_t'(lo);
    end
    return axis_t'(v);
  endfunction

endpackage

### rtl/jcam_if.sv
// sample channel
interface jcam_in_if import jcam_pkg::*; ();
  logic    valid;
  logic    ready;
  logic    operation;
  sample_t sample_x;
  sample_t sample_y;

  modport source (output valid, output operation, output sample_x, output sample_y,
                  input ready);
  modport sink (input valid, input operation, input sample_x, input sample_y,
                output ready);
endinterface

// result channel
interface jcam_out_if import jcam_pkg::*; ();
  logic  valid;
  logic  ready;
  axis_t axis_x;
  axis_t axis_y;

  modport source (output valid, output axis_x, output axis_y, input ready);
  modport sink (input valid, input axis_x, input axis_y, output ready);
endinterface

### rtl/jcam_ctrl.sv
module jcam_ctrl import jcam_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    out_free,
  input  status_t status,
  output logic    in_ready,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;
  logic   axis;
  logic   axis_next;

  // state and axis registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      axis  <= 1'b0;
    end else begin
      state <= state_next;
      axis  <= axis_next;
    end
  end

  // sequencing
  always_comb begin
    state_next  = state;
    axis_next   = axis;
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.mul_sel = MUL_DX;
    cmd.axis    = axis;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SQ_X;
        end
      end
      S_SQ_X: begin
        cmd.mul_sel = MUL_DX;
        state_next  = S_SQ_Y;
      end
      S_SQ_Y: begin
        cmd.mul_sel  = MUL_DY;
        cmd.acc_load = 1'b1;
        state_next   = S_SQ_R;
      end
      S_SQ_R: begin
        cmd.mul_sel = MUL_DZ;
        cmd.acc_add = 1'b1;
        state_next  = S_CMP;
      end
      S_CMP: begin
        cmd.cmp    = 1'b1;
        axis_next  = 1'b0;
        state_next = S_SETUP;
      end
      S_SETUP: begin
        cmd.mul_sel = MUL_NUM;
        cmd.setup   = 1'b1;
        state_next  = S_DINIT;
      end
      S_DINIT: begin
        cmd.dinit  = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_STORE;
        end
      end
      S_STORE: begin
        cmd.store = 1'b1;
        if (axis) begin
          state_next = S_FINISH;
        end else begin
          axis_next  = 1'b1;
          state_next = S_SETUP;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/jcam_datapath.sv
module jcam_datapath import jcam_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    cfg_wr_en,
  input  sample_t cfg_wr_data,
  input  logic    in_operation,
  input  sample_t in_sample_x,
  input  sample_t in_sample_y,
  input  cmd_t    cmd,
  output status_t status,
  output axis_t   res_x,
  output axis_t   res_y
);

  sample_t dz_radius;
  sample_t amin [2];
  sample_t amax [2];
  sample_t centre [2];
  sample_t smp [2];
  sample_t in_smp [2];
  logic    refine;

  logic signed [PROD_W-1:0] prod;
  logic [ACC_W-1:0]         acc;
  logic                     outside;
  seg_t                     seg;
  logic [DEN_W-1:0]         den;
  logic [DEN_W-1:0]         rem;
  logic [QUO_W-1:0]         quo;
  logic [CNT_W-1:0]         cnt;
  axis_t                    res [2];

  logic signed [SW-1:0] dx, dy, ma, mb, dz_s;
  logic signed [EW-1:0] v, lo, hi, c, dz_e, edge_lo, edge_hi;
  logic signed [EW-1:0] span_lo, span_hi, diff;
  logic                 below, above;
  logic [DEN_W:0]       trial;
  logic                 ge;
  wide_t                low_val;
  axis_t                res_val;
  logic [ADC_BITS:0]    csum [2];

  assign in_smp[0] = in_sample_x;
  assign in_smp[1] = in_sample_y;

  // deltas from centre for the deadzone test
  assign dx   = signed'({1'b0, smp[0]}) - signed'({1'b0, centre[0]});
  assign dy   = signed'({1'b0, smp[1]}) - signed'({1'b0, centre[1]});
  assign dz_s = signed'({1'b0, dz_radius});

  // per axis edges and spans
  assign v       = signed'({2'b00, smp[cmd.axis]});
  assign lo      = signed'({2'b00, amin[cmd.axis]});
  assign hi      = signed'({2'b00, amax[cmd.axis]});
  assign c       = signed'({2'b00, centre[cmd.axis]});
  assign dz_e    = signed'({2'b00, dz_radius});
  assign edge_lo = c - dz_e;
  assign edge_hi = c + dz_e;
  assign below   = v < edge_lo;
  assign above   = v > edge_hi;
  assign span_lo = edge_lo - lo;
  assign span_hi = hi - edge_hi;
  assign diff    = below ? (v - lo) : (v - edge_hi);

  // shared multiplier operands
  always_comb begin
    unique case (cmd.mul_sel)
      MUL_DX: begin
        ma = dx;
        mb = dx;
      end
      MUL_DY: begin
        ma = dy;
        mb = dy;
      end
      MUL_DZ: begin
        ma = dz_s;
        mb = dz_s;
      end
      MUL_NUM: begin
        ma = diff[SW-1:0];
        mb = SW'(FULL_SCALE_OUT);
      end
      default: begin
        ma = dx;
        mb = dx;
      end
    endcase
  end

  // restoring divide step, one quotient bit
  assign trial = {rem, quo[QUO_W-1]};
  assign ge    = trial >= {1'b0, den};

  // segment result
  assign low_val = wide_t'(signed'({1'b0, quo})) - wide_t'(FULL_SCALE_OUT);
  always_comb begin
    unique case (seg)
      SEG_ZERO:    res_val = '0;
      SEG_LOW:     res_val = sat_out(low_val);
      SEG_HIGH:    res_val = sat_out(wide_t'(signed'({1'b0, quo})));
      SEG_MIN_END: res_val = -axis_t'(FULL_SCALE_OUT);
      SEG_MAX_END: res_val = axis_t'(FULL_SCALE_OUT);
      default:     res_val = '0;
    endcase
  end

  assign csum[0] = {1'b0, centre[0]} + {1'b0, smp[0]};
  assign csum[1] = {1'b0, centre[1]} + {1'b0, smp[1]};

  // calibration state and deadzone register
  always_ff @(posedge clk) begin
    if (rst) begin
      dz_radius <= DEADZONE_RESET;
      for (int i = 0; i < 2; i++) begin
        amin[i]   <= ADC_FULL;
        amax[i]   <= '0;
        centre[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        dz_radius <= cfg_wr_data;
      end
      // widen the range on every item
      if (cmd.load) begin
        for (int i = 0; i < 2; i++) begin
          if (in_smp[i] < amin[i]) begin
            amin[i] <= in_smp[i];
          end
          if (in_smp[i] > amax[i]) begin
            amax[i] <= in_smp[i];
          end
        end
      end
      // centre refinement after the result is out
      if (cmd.finish && refine) begin
        for (int i = 0; i < 2; i++) begin
          if (centre[i] == '0) begin
            centre[i] <= smp[i];
          end else begin
            centre[i] <= csum[i][ADC_BITS:1];
          end
        end
      end
    end
  end

  // item payload and arithmetic registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      smp[0] <= in_sample_x;
      smp[1] <= in_sample_y;
      refine <= (op_t'(in_operation) == OP_REFINE);
    end
    prod <= ma * mb;
    if (cmd.acc_load) begin
      acc <= ACC_W'(unsigned'(prod));
    end else if (cmd.acc_add) begin
      acc <= acc + ACC_W'(unsigned'(prod));
    end
    if (cmd.cmp) begin
      outside <= acc >= ACC_W'(unsigned'(prod));
    end
    // choose the segment and latch its span
    if (cmd.setup) begin
      den <= '0;
      if (!outside) begin
        seg <= SEG_ZERO;
      end else if (below) begin
        seg <= (span_lo <= 0) ? SEG_MIN_END : SEG_LOW;
        den <= span_lo[DEN_W-1:0];
      end else if (above) begin
        seg <= (span_hi <= 0) ? SEG_MAX_END : SEG_HIGH;
        den <= span_hi[DEN_W-1:0];
      end else begin
        seg <= SEG_ZERO;
      end
    end
    // quotient fits QUO_W bits, so the top part starts below the divisor
    if (cmd.dinit) begin
      rem <= DEN_W'(prod[NUM_W-1:QUO_W]);
      quo <= prod[QUO_W-1:0];
    end else if (cmd.div_step) begin
      rem <= ge ? DEN_W'(trial - {1'b0, den}) : DEN_W'(trial);
      quo <= {quo[QUO_W-2:0], ge};
    end
    if (cmd.store) begin
      res[cmd.axis] <= res_val;
    end
  end

  // divide iteration counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.dinit) begin
      cnt <= CNT_W'(QUO_W - 1);
    end else if (cmd.div_step && cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  assign status.div_last = (cnt == '0);
  assign res_x = res[0];
  assign res_y = res[1];

endmodule

### rtl/joystick_calibrated_axis_mapper.sv
// one item at a time: a new item is taken only after the last one's result
//   is loaded into the output register; a shared 13x13 multiplier and a 10-step
//   restoring divider run per axis in turn
// a finished result waits in the output register while the next item is taken
// reset: synchronous, active high; deadzone radius 100, minimum 4095, maximum
//   and centre zero, no result pending
module joystick_calibrated_axis_mapper import jcam_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_wr_en,
  input  sample_t         cfg_wr_data,
  jcam_in_if.sink         samples,
  jcam_out_if.source      results
);

  cmd_t    cmd;
  status_t status;
  logic    out_free;
  axis_t   res_x;
  axis_t   res_y;

  assign out_free = !results.valid || results.ready;

  jcam_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .out_free (out_free),
    .status   (status),
    .in_ready (samples.ready),
    .cmd      (cmd)
  );

  jcam_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_operation (samples.operation),
    .in_sample_x  (samples.sample_x),
    .in_sample_y  (samples.sample_y),
    .cmd          (cmd),
    .status       (status),
    .res_x        (res_x),
    .res_y        (res_y)
  );

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (cmd.finish) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      results.axis_x <= res_x;
      results.axis_y <= res_y;
    end
  end

  // a result is only loaded into a free output register
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!results.valid || results.ready))
    else $error("result loaded over a pending item");

  // a new result appears only from a finished item
  a_rise_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(results.valid) |-> $past(cmd.finish))
    else $error("result valid without a finished item");

  // one item at a time in the datapath
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (samples.valid && samples.ready) |=> !samples.ready)
    else $error("second item accepted while busy");

  // results stay within full scale
  a_range: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (results.axis_x >= -FULL_SCALE_OUT && results.axis_x <= FULL_SCALE_OUT
                    && results.axis_y >= -FULL_SCALE_OUT && results.axis_y <= FULL_SCALE_OUT))
    else $error("axis value out of range");

endmodule

### test/jcam_axis_checker.sv
// watches the sample and result channels, predicts each result and compares
module jcam_axis_checker import jcam_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    cfg_wr_en,
  input  sample_t cfg_wr_data,
  jcam_in_if      samples,
  jcam_out_if     results,
  output int      fails,
  output int      pending
);

  typedef struct packed {
    axis_t x;
    axis_t y;
  } deflection_t;

  // predicted calibration state
  sample_t     lo_code [2];
  sample_t     hi_code [2];
  sample_t     centre_code [2];
  sample_t     radius_code;
  deflection_t deflection_q [$];
  int          mismatches = 0;

  assign fails = mismatches;

  task automatic report(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // piecewise linear transfer of one axis, truncating division, clamped
  function automatic axis_t map_axis(longint v, longint lo, longint hi, longint c,
                                     longint dz);
    longint knee;
    longint span;
    longint q;
    longint full;
    full = longint'(FULL_SCALE_OUT);
    if (v < c - dz) begin
      knee = c - dz;
      span = knee - lo;
      if (span <= 0) return axis_t'(-full);
      q = -full + ((v - lo) * full) / span;
    end else if (v > c + dz) begin
      knee = c + dz;
      span = hi - knee;
      if (span <= 0) return axis_t'(full);
      q = ((v - knee) * full) / span;
    end else begin
      return '0;
    end
    if (q > full) q = full;
    if (q < -full) q = -full;
    return axis_t'(q);
  endfunction

  // widen the range, map both axes, then refine the centre if asked
  function automatic deflection_t predict_deflection(op_t op, sample_t sx, sample_t sy);
    sample_t     s [2];
    longint      dx;
    longint      dy;
    longint      dz;
    deflection_t d;
    s[0] = sx;
    s[1] = sy;
    for (int i = 0; i < 2; i++) begin
      if (s[i] < lo_code[i]) lo_code[i] = s[i];
      if (s[i] > hi_code[i]) hi_code[i] = s[i];
    end
    dz = longint'(radius_code);
    dx = longint'(s[0]) - longint'(centre_code[0]);
    dy = longint'(s[1]) - longint'(centre_code[1]);
    d = '0;
    if (dx * dx + dy * dy >= dz * dz) begin
      d.x = map_axis(s[0], lo_code[0], hi_code[0], centre_code[0], dz);
      d.y = map_axis(s[1], lo_code[1], hi_code[1], centre_code[1], dz);
    end
    if (op == OP_REFINE) begin
      for (int i = 0; i < 2; i++) begin
        if (centre_code[i] == '0) begin
          centre_code[i] = s[i];
        end else begin
          centre_code[i] = sample_t'((int'(centre_code[i]) + int'(s[i])) / 2);
        end
      end
    end
    return d;
  endfunction

  // track config writes, accepted items and returned results
  always @(posedge clk) begin : track
    deflection_t want;
    if (rst) begin
      radius_code = DEADZONE_RESET;
      for (int i = 0; i < 2; i++) begin
        lo_code[i]     = ADC_FULL;
        hi_code[i]     = '0;
        centre_code[i] = '0;
      end
      deflection_q.delete();
    end else begin
      if (cfg_wr_en) radius_code = cfg_wr_data;
      // results first, so an early result cannot consume this cycle's item
      if (results.valid && results.ready) begin
        if (deflection_q.size() == 0) begin
          report($sformatf("result (%0d, %0d) with no item waiting",
                           results.axis_x, results.axis_y));
        end else begin
          want = deflection_q.pop_front();
          if (results.axis_x !== want.x)
            report($sformatf("axis_x got %0d want %0d", results.axis_x, want.x));
          if (results.axis_y !== want.y)
            report($sformatf("axis_y got %0d want %0d", results.axis_y, want.y));
        end
      end
      if (samples.valid && samples.ready) begin
        deflection_q.push_back(predict_deflection(op_t'(samples.operation),
                                                  samples.sample_x, samples.sample_y));
      end
    end
    pending <= deflection_q.size();
  end

endmodule

### test/tb_joystick_calibrated_axis_mapper.sv
module tb_joystick_calibrated_axis_mapper;
  import jcam_pkg::*;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 40;
  localparam int MAX_IDLE      = 18;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 125;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    cfg_wr_en = 1'b0;
  sample_t cfg_wr_data = '0;
  int      cycles = 0;
  int      radius = 100;
  bit      quiet = 1'b0;
  int      fails;
  int      pending;

  jcam_in_if  samples ();
  jcam_out_if results ();

  always #6 clk = ~clk;

  joystick_calibrated_axis_mapper dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .samples     (samples),
    .results     (results)
  );

  jcam_axis_checker axis_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .samples     (samples),
    .results     (results),
    .fails       (fails),
    .pending     (pending)
  );

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int idle_gap();
    if (quiet) return 0;
    return $urandom_range(0, MAX_IDLE);
  endfunction

  function automatic sample_t clip(int v);
    if (v < 0) return '0;
    if (v > int'(ADC_FULL)) return ADC_FULL;
    return sample_t'(v);
  endfunction

  function automatic sample_t rail();
    case ($urandom_range(0, 2))
      0: return '0;
      1: return ADC_FULL;
      default: return sample_t'($urandom_range(0, 4095));
    endcase
  endfunction

  // offer one item after a random gap and hold it until taken
  task automatic send_item(op_t op, sample_t sx, sample_t sy);
    int gap;
    if ($urandom_range(0, 39) == 0) quiet = !quiet;
    gap = idle_gap();
    if (gap > 0) begin
      samples.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    samples.valid     <= 1'b1;
    samples.operation <= op;
    samples.sample_x  <= sx;
    samples.sample_y  <= sy;
    do @(posedge clk); while (!samples.ready);
  endtask

  // drain every outstanding result, then give the block time to go idle
  task automatic settle();
    samples.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_radius(int r);
    radius      = r;
    cfg_wr_data <= sample_t'(r);
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // extremes, centre set and averaging, deadzone circle, centre near the rails
  task automatic directed_items();
    send_item(OP_NORMAL, 12'd2048, 12'd2048);
    send_item(OP_NORMAL, 12'd0, 12'd0);
    send_item(OP_NORMAL, 12'd4095, 12'd4095);
    send_item(OP_NORMAL, 12'd0, 12'd4095);
    send_item(OP_REFINE, 12'd2048, 12'd2048);
    send_item(OP_REFINE, 12'd2050, 12'd2046);
    // exactly on the deadzone circle counts as outside
    send_item(OP_NORMAL, 12'd2149, 12'd2047);
    send_item(OP_NORMAL, 12'd2109, 12'd2127);
    send_item(OP_NORMAL, 12'd2109, 12'd2126);
    send_item(OP_NORMAL, 12'd2150, 12'd1946);
    send_item(OP_NORMAL, 12'd4095, 12'd0);
    send_item(OP_NORMAL, 12'd1024, 12'd3072);
    // walk the centre toward the rails so the knees leave the code range
    repeat (5) send_item(OP_REFINE, 12'd0, 12'd4095);
    send_item(OP_NORMAL, 12'd0, 12'd0);
    send_item(OP_NORMAL, 12'd4095, 12'd4095);
    send_item(OP_NORMAL, 12'd0, 12'd4095);
    send_item(OP_NORMAL, 12'd4095, 12'd0);
  endtask

  // most often around a rest point, some on the deadzone ring, rails and noise
  task automatic random_item(int rest_x, int rest_y);
    int      spread;
    op_t     op;
    sample_t sx;
    sample_t sy;
    spread = radius * 2 + 16;
    op = ($urandom_range(0, 9) == 0) ? OP_REFINE : OP_NORMAL;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        sx = clip(rest_x + int'($urandom_range(0, 2 * spread)) - spread);
        sy = clip(rest_y + int'($urandom_range(0, 2 * spread)) - spread);
        if ($urandom_range(0, 1) == 1) op = OP_REFINE;
      end
      7: begin
        sx = rail();
        sy = rail();
      end
      8, 9: begin
        sx = clip(rest_x + ($urandom_range(0, 1) == 1 ? radius : -radius)
                  + int'($urandom_range(0, 2)) - 1);
        sy = clip(rest_y + int'($urandom_range(0, 2)) - 1);
      end
      default: begin
        sx = sample_t'($urandom_range(0, 4095));
        sy = sample_t'($urandom_range(0, 4095));
      end
    endcase
    send_item(op, sx, sy);
  endtask

  // result side: random stalls on ready
  initial begin
    int stall;
    results.ready = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      stall = idle_gap();
      if (stall > 0) begin
        results.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      results.ready <= 1'b1;
      do @(posedge clk); while (!results.valid);
    end
  end

  // stimulus and verdict
  initial begin
    int rest_x;
    int rest_y;
    int r;
    samples.valid     = 1'b0;
    samples.operation = OP_NORMAL;
    samples.sample_x  = '0;
    samples.sample_y  = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed_items();
    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0: r = 0;
        1: r = 4095;
        2: r = 1;
        3: r = 2047;
        default: r = $urandom_range(0, 400);
      endcase
      write_radius(r);
      rest_x = $urandom_range(0, 4095);
      rest_y = $urandom_range(0, 4095);
      repeat (PHASE_ITEMS) random_item(rest_x, rest_y);
    end
    settle();
    @(negedge clk);
    if (fails == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
